>>> rtl/core/smx_pkg.sv
`default_nettype none

package smx_pkg;

  // Default configuration
  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;

  // Fixed field widths of the transaction payloads
  localparam int OUT_WIDTH = 32;
  localparam int POS_WIDTH = 7;

  // Decoded instruction codes
  typedef enum logic [2:0] {
    REQ_PUSH    = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_SUB     = 3'd2,
    REQ_DIV     = 3'd3,
    REQ_MUL     = 3'd4,
    REQ_OUT     = 3'd5,
    REQ_HALT    = 3'd6,
    REQ_INVALID = 3'd7
  } req_op_t;

  // Result status codes
  typedef enum logic [3:0] {
    STAT_OK       = 4'd0,
    STAT_ANSWER   = 4'd1,
    STAT_EMPTY    = 4'd2,
    STAT_LIST     = 4'd3,
    STAT_HALTED   = 4'd4,
    STAT_UNDERFLOW = 4'd5,
    STAT_INVALID  = 4'd6,
    STAT_IGNORED  = 4'd7,
    STAT_DIVZERO  = 4'd8,
    STAT_OVERFLOW = 4'd9
  } status_t;

  typedef struct packed {
    req_op_t                     req_type;
    logic signed [OUT_WIDTH-1:0] push_data;
  } req_t;

  typedef struct packed {
    status_t                     status;
    logic signed [OUT_WIDTH-1:0] value;
    logic [POS_WIDTH-1:0]        position;
    logic                        last;
  } rsp_t;

  // Controller states
  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_RD_TOP,
    FSM_RD_SECOND,
    FSM_CHECK,
    FSM_MD_WAIT,
    FSM_WRITEBACK,
    FSM_EMIT,
    FSM_LIST
  } fsm_state_t;

  // Stack read address select
  typedef enum logic [1:0] {
    RD_TOP,
    RD_SECOND,
    RD_FIRST,
    RD_NEXT
  } rd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch_req;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_push;
    logic    wr_result;
    logic    set_halt;
    logic    set_pend;
    status_t pend_code;
    logic    cap_first;
    logic    cap_second;
    logic    calc_addsub;
    logic    md_start;
    logic    md_capture;
    logic    list_start;
    logic    list_load;
    logic    load_single;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_op_t op;
    logic    halted;
    logic    full;
    logic    below_two;
    logic    empty;
    logic    first_zero;
    logic    md_done;
    logic    out_free;
    logic    list_last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/smx_muldiv.sv
`default_nettype none

// Shared iterative multiply / divide unit, one bit per cycle.
// Multiply keeps the low VALUE_WIDTH bits; divide truncates toward zero.
module smx_muldiv #(
  parameter int VALUE_WIDTH = smx_pkg::VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   op_div,
  input  logic [VALUE_WIDTH-1:0] opnd_a,
  input  logic [VALUE_WIDTH-1:0] opnd_b,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int VW = VALUE_WIDTH;
  localparam int SW = $clog2(VW + 1);

  logic          busy;
  logic          fin;
  logic [SW-1:0] step;
  logic          div_mode;
  logic          neg;
  logic [VW-1:0] x;
  logic [VW-1:0] y;
  logic [VW-1:0] acc;

  logic [VW:0]   rem_sh;
  logic [VW+1:0] diff;
  logic          borrow;

  // Restoring divide step
  assign rem_sh = {acc, x[VW-1]};
  assign diff   = {1'b0, rem_sh} - (VW + 2)'(y);
  assign borrow = diff[VW+1];

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + SW'(1);
        if (step == SW'(VW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      div_mode <= op_div;
      acc      <= '0;
      if (op_div) begin
        x   <= opnd_a[VW-1] ? (VW'(0) - opnd_a) : opnd_a;
        y   <= opnd_b[VW-1] ? (VW'(0) - opnd_b) : opnd_b;
        neg <= opnd_a[VW-1] ^ opnd_b[VW-1];
      end else begin
        x   <= opnd_a;
        y   <= opnd_b;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (div_mode) begin
        acc <= borrow ? rem_sh[VW-1:0] : diff[VW-1:0];
        x   <= {x[VW-2:0], ~borrow};
      end else begin
        acc <= acc + (y[0] ? x : VW'(0));
        x   <= {x[VW-2:0], 1'b0};
        y   <= {1'b0, y[VW-1:1]};
      end
    end else if (fin) begin
      if (div_mode) begin
        result <= neg ? (VW'(0) - x) : x;
      end else begin
        result <= acc;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/smx_datapath.sv
`default_nettype none

// Stack storage, counters, operand registers and the response register.
module smx_datapath #(
  parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH,
  parameter int VALUE_WIDTH = smx_pkg::VALUE_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  smx_pkg::req_t       req,
  input  smx_pkg::dp_cmd_t    cmd,
  output smx_pkg::dp_status_t sts,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output smx_pkg::rsp_t       rsp
);

  localparam int VW = VALUE_WIDTH;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int OW = smx_pkg::OUT_WIDTH;
  localparam int PW = smx_pkg::POS_WIDTH;
  localparam int EW = (VW > OW) ? VW : OW;

  logic [VW-1:0] mem [STACK_DEPTH];

  smx_pkg::req_t   req_q;
  smx_pkg::status_t pend;
  logic [CW-1:0]   cnt;
  logic            halted;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   idx_plus;
  logic [VW-1:0]   rd_data;
  logic [VW-1:0]   opa;
  logic [VW-1:0]   opb;
  logic [VW-1:0]   res;
  logic [CW-1:0]   rd_idx;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [VW-1:0]   wr_data;
  logic            wr_en;
  logic [EW-1:0]   rd_ext;
  logic [EW-1:0]   pv_ext;
  logic            out_free;
  logic            md_done;
  logic [VW-1:0]   md_result;

  // Width adaptation of stored values
  assign rd_ext   = EW'(signed'(rd_data));
  assign pv_ext   = EW'(req_q.push_data);
  assign idx_plus = idx + CW'(1);
  assign out_free = ~rsp_valid | rsp_ready;

  // Status toward the controller
  always_comb begin
    sts.op         = req_q.req_type;
    sts.halted     = halted;
    sts.full       = (cnt >= CW'(STACK_DEPTH));
    sts.below_two  = (cnt < CW'(2));
    sts.empty      = (cnt == '0);
    sts.first_zero = (opa == '0);
    sts.md_done    = md_done;
    sts.out_free   = out_free;
    sts.list_last  = (idx_plus == cnt);
  end

  // Stack read address
  always_comb begin
    case (cmd.rd_sel)
      smx_pkg::RD_TOP:    rd_idx = cnt - CW'(1);
      smx_pkg::RD_SECOND: rd_idx = cnt - CW'(2);
      smx_pkg::RD_FIRST:  rd_idx = '0;
      smx_pkg::RD_NEXT:   rd_idx = idx_plus;
      default:            rd_idx = '0;
    endcase
    rd_addr = rd_idx[AW-1:0];
  end

  function automatic logic [AW-1:0] rd_idx_wb(input logic [CW-1:0] c);
    logic [CW-1:0] t;
    t = c - CW'(2);
    return t[AW-1:0];
  endfunction

  // Stack write port
  always_comb begin
    wr_en = cmd.wr_push | cmd.wr_result;
    if (cmd.wr_push) begin
      wr_addr = cnt[AW-1:0];
      wr_data = pv_ext[VW-1:0];
    end else begin
      wr_addr = rd_idx_wb(cnt);
      wr_data = res;
    end
  end

  // Stack memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Stack pointer and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      halted <= 1'b0;
    end else begin
      if (cmd.wr_push) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.wr_result) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.set_halt) begin
        halted <= 1'b1;
      end
    end
  end

  // Request, operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_q <= req;
    end
    if (cmd.set_pend) begin
      pend <= cmd.pend_code;
    end
    if (cmd.cap_first) begin
      opa <= rd_data;
    end
    if (cmd.cap_second) begin
      opb <= rd_data;
    end
    if (cmd.calc_addsub) begin
      res <= (req_q.req_type == smx_pkg::REQ_SUB) ? (opb - opa) : (opb + opa);
    end else if (cmd.md_capture) begin
      res <= md_result;
    end
    if (cmd.list_start) begin
      idx <= '0;
    end else if (cmd.list_load) begin
      idx <= idx_plus;
    end
  end

  // Shared multiply / divide unit: second operand op first operand
  smx_muldiv #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.md_start),
    .op_div (req_q.req_type == smx_pkg::REQ_DIV),
    .opnd_a (opb),
    .opnd_b (opa),
    .done   (md_done),
    .result (md_result)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_single | cmd.list_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      rsp.status   <= pend;
      rsp.value    <= '0;
      rsp.position <= '0;
      rsp.last     <= 1'b1;
    end else if (cmd.list_load) begin
      rsp.status   <= (cnt == CW'(1)) ? smx_pkg::STAT_ANSWER : smx_pkg::STAT_LIST;
      rsp.value    <= rd_ext[OW-1:0];
      rsp.position <= PW'(idx) + PW'(1);
      rsp.last     <= sts.list_last;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted state released without reset");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_single || cmd.list_load) |-> out_free)
    else $error("response register overwritten while held");

  a_push_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_push |-> (!halted && cnt < CW'(STACK_DEPTH)))
    else $error("push written while halted or full");

endmodule

`default_nettype wire

>>> rtl/core/smx_ctrl.sv
`default_nettype none

// Instruction sequencer for the stack machine.
module smx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  smx_pkg::dp_status_t sts,
  output smx_pkg::dp_cmd_t    cmd
);

  smx_pkg::fsm_state_t state;
  smx_pkg::fsm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smx_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      smx_pkg::FSM_IDLE: begin
        if (req_valid) begin
          state_next = smx_pkg::FSM_DECODE;
        end
      end
      smx_pkg::FSM_DECODE: begin
        if (sts.halted) begin
          state_next = smx_pkg::FSM_EMIT;
        end else if (sts.op inside {smx_pkg::REQ_ADD, smx_pkg::REQ_SUB,
                                    smx_pkg::REQ_DIV, smx_pkg::REQ_MUL}) begin
          state_next = sts.below_two ? smx_pkg::FSM_EMIT : smx_pkg::FSM_RD_TOP;
        end else if (sts.op == smx_pkg::REQ_OUT) begin
          state_next = sts.empty ? smx_pkg::FSM_EMIT : smx_pkg::FSM_LIST;
        end else begin
          state_next = smx_pkg::FSM_EMIT;
        end
      end
      smx_pkg::FSM_RD_TOP:    state_next = smx_pkg::FSM_RD_SECOND;
      smx_pkg::FSM_RD_SECOND: state_next = smx_pkg::FSM_CHECK;
      smx_pkg::FSM_CHECK: begin
        if (sts.op == smx_pkg::REQ_DIV && sts.first_zero) begin
          state_next = smx_pkg::FSM_EMIT;
        end else if (sts.op inside {smx_pkg::REQ_ADD, smx_pkg::REQ_SUB}) begin
          state_next = smx_pkg::FSM_WRITEBACK;
        end else begin
          state_next = smx_pkg::FSM_MD_WAIT;
        end
      end
      smx_pkg::FSM_MD_WAIT: begin
        if (sts.md_done) begin
          state_next = smx_pkg::FSM_WRITEBACK;
        end
      end
      smx_pkg::FSM_WRITEBACK: state_next = smx_pkg::FSM_EMIT;
      smx_pkg::FSM_EMIT: begin
        if (sts.out_free) begin
          state_next = smx_pkg::FSM_IDLE;
        end
      end
      smx_pkg::FSM_LIST: begin
        if (sts.out_free && sts.list_last) begin
          state_next = smx_pkg::FSM_IDLE;
        end
      end
      default: state_next = smx_pkg::FSM_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = smx_pkg::RD_TOP;
    cmd.pend_code = smx_pkg::STAT_OK;
    req_ready     = 1'b0;
    case (state)
      smx_pkg::FSM_IDLE: begin
        req_ready     = 1'b1;
        cmd.latch_req = req_valid;
      end
      smx_pkg::FSM_DECODE: begin
        if (sts.halted) begin
          cmd.set_pend  = 1'b1;
          cmd.pend_code = smx_pkg::STAT_IGNORED;
        end else if (sts.op == smx_pkg::REQ_PUSH) begin
          cmd.set_pend = 1'b1;
          if (sts.full) begin
            cmd.set_halt  = 1'b1;
            cmd.pend_code = smx_pkg::STAT_OVERFLOW;
          end else begin
            cmd.wr_push   = 1'b1;
            cmd.pend_code = smx_pkg::STAT_OK;
          end
        end else if (sts.op inside {smx_pkg::REQ_ADD, smx_pkg::REQ_SUB,
                                    smx_pkg::REQ_DIV, smx_pkg::REQ_MUL}) begin
          if (sts.below_two) begin
            cmd.set_halt  = 1'b1;
            cmd.set_pend  = 1'b1;
            cmd.pend_code = smx_pkg::STAT_UNDERFLOW;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = smx_pkg::RD_TOP;
          end
        end else if (sts.op == smx_pkg::REQ_OUT) begin
          if (sts.empty) begin
            cmd.set_pend  = 1'b1;
            cmd.pend_code = smx_pkg::STAT_EMPTY;
          end else begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = smx_pkg::RD_FIRST;
            cmd.list_start = 1'b1;
          end
        end else begin
          cmd.set_halt  = 1'b1;
          cmd.set_pend  = 1'b1;
          cmd.pend_code = (sts.op == smx_pkg::REQ_HALT) ? smx_pkg::STAT_HALTED
                                                        : smx_pkg::STAT_INVALID;
        end
      end
      smx_pkg::FSM_RD_TOP: begin
        cmd.cap_first = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = smx_pkg::RD_SECOND;
      end
      smx_pkg::FSM_RD_SECOND: begin
        cmd.cap_second = 1'b1;
      end
      smx_pkg::FSM_CHECK: begin
        if (sts.op == smx_pkg::REQ_DIV && sts.first_zero) begin
          cmd.set_halt  = 1'b1;
          cmd.set_pend  = 1'b1;
          cmd.pend_code = smx_pkg::STAT_DIVZERO;
        end else if (sts.op inside {smx_pkg::REQ_ADD, smx_pkg::REQ_SUB}) begin
          cmd.calc_addsub = 1'b1;
        end else begin
          cmd.md_start = 1'b1;
        end
      end
      smx_pkg::FSM_MD_WAIT: begin
        cmd.md_capture = sts.md_done;
      end
      smx_pkg::FSM_WRITEBACK: begin
        cmd.wr_result = 1'b1;
        cmd.set_pend  = 1'b1;
        cmd.pend_code = smx_pkg::STAT_OK;
      end
      smx_pkg::FSM_EMIT: begin
        cmd.load_single = sts.out_free;
      end
      smx_pkg::FSM_LIST: begin
        if (sts.out_free) begin
          cmd.list_load = 1'b1;
          if (!sts.list_last) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = smx_pkg::RD_NEXT;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/stack_machine_executor_core.sv
// One instruction at a time; req_ready is high only while the sequencer is idle.
// Push, hlt, invalid, underflow and ignored respond from decode; divide by zero after the
// operand reads and check; add and sub after writeback; mul and div also wait on the
// one-bit-per-cycle shared multiply/divide unit. Out lists one element per cycle, while
// the response side accepts, through the single stack read port. Sync reset empties the
// stack and resumes.
`default_nettype none

module stack_machine_executor_core #(
  parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH,
  parameter int VALUE_WIDTH = smx_pkg::VALUE_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  smx_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output smx_pkg::rsp_t rsp
);

  smx_pkg::dp_cmd_t    cmd;
  smx_pkg::dp_status_t sts;

  // Sequencer
  smx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stack and arithmetic
  smx_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps

// Scoreboard: mirrors the stack, predicts the responses of each instruction and
// checks the responses in order.
class exec_scoreboard;
  logic [31:0]   stack_mem [smx_pkg::STACK_DEPTH];
  int unsigned   depth_used;
  bit            halted;
  smx_pkg::rsp_t expected_rsps [$];
  int unsigned   error_count;

  function new();
    depth_used  = 0;
    halted      = 1'b0;
    error_count = 0;
  endfunction

  // Signed divide on magnitudes, truncating toward zero; min / -1 wraps to min
  function logic [31:0] quotient(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_n, mag_d, q;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    q     = mag_n / mag_d;
    return (num[31] ^ den[31]) ? -q : q;
  endfunction

  function int unsigned pending();
    return expected_rsps.size();
  endfunction

  // Update the mirrored stack for one accepted instruction and queue its responses
  function void note_instruction(smx_pkg::req_t item);
    smx_pkg::rsp_t rsp_exp;
    logic [31:0]   first_op, second_op;
    rsp_exp      = '0;
    rsp_exp.last = 1'b1;
    if (halted) begin
      rsp_exp.status = smx_pkg::STAT_IGNORED;
    end else begin
      case (item.req_type)
        smx_pkg::REQ_PUSH: begin
          if (depth_used >= smx_pkg::STACK_DEPTH) begin
            halted         = 1'b1;
            rsp_exp.status = smx_pkg::STAT_OVERFLOW;
          end else begin
            stack_mem[depth_used] = item.push_data;
            depth_used++;
            rsp_exp.status = smx_pkg::STAT_OK;
          end
        end
        smx_pkg::REQ_ADD, smx_pkg::REQ_SUB, smx_pkg::REQ_DIV, smx_pkg::REQ_MUL: begin
          if (depth_used < 2) begin
            halted         = 1'b1;
            rsp_exp.status = smx_pkg::STAT_UNDERFLOW;
          end else begin
            first_op  = stack_mem[depth_used-1];
            second_op = stack_mem[depth_used-2];
            if (item.req_type == smx_pkg::REQ_DIV && first_op == 32'd0) begin
              halted         = 1'b1;
              rsp_exp.status = smx_pkg::STAT_DIVZERO;
            end else begin
              depth_used--;
              case (item.req_type)
                smx_pkg::REQ_ADD: stack_mem[depth_used-1] = second_op + first_op;
                smx_pkg::REQ_SUB: stack_mem[depth_used-1] = second_op - first_op;
                smx_pkg::REQ_DIV: stack_mem[depth_used-1] = quotient(second_op, first_op);
                default:          stack_mem[depth_used-1] = second_op * first_op;
              endcase
              rsp_exp.status = smx_pkg::STAT_OK;
            end
          end
        end
        smx_pkg::REQ_OUT: begin
          if (depth_used == 0) begin
            rsp_exp.status = smx_pkg::STAT_EMPTY;
          end else if (depth_used == 1) begin
            rsp_exp.status   = smx_pkg::STAT_ANSWER;
            rsp_exp.value    = stack_mem[0];
            rsp_exp.position = 7'd1;
          end else begin
            // bottom to top, last flag on the top element
            for (int unsigned k = 0; k < depth_used; k++) begin
              rsp_exp.status   = smx_pkg::STAT_LIST;
              rsp_exp.value    = stack_mem[k];
              rsp_exp.position = 7'(k + 1);
              rsp_exp.last     = (k + 1 == depth_used);
              expected_rsps.push_back(rsp_exp);
            end
            return;
          end
        end
        smx_pkg::REQ_HALT: begin
          halted         = 1'b1;
          rsp_exp.status = smx_pkg::STAT_HALTED;
        end
        default: begin
          halted         = 1'b1;
          rsp_exp.status = smx_pkg::STAT_INVALID;
        end
      endcase
    end
    expected_rsps.push_back(rsp_exp);
  endfunction

  // Compare one accepted response with the oldest prediction
  function void check_response(smx_pkg::rsp_t got);
    smx_pkg::rsp_t want;
    if (expected_rsps.size() == 0) begin
      $error("unexpected response: status %0d value %0d position %0d last %0d",
             got.status, got.value, got.position, got.last);
      error_count++;
      return;
    end
    want = expected_rsps.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      error_count++;
    end
    if (got.value !== want.value) begin
      $error("value: expected %0d, actual %0d", want.value, got.value);
      error_count++;
    end
    if (got.position !== want.position) begin
      $error("position: expected %0d, actual %0d", want.position, got.position);
      error_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      error_count++;
    end
  endfunction
endclass

module testbench;

  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  smx_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  smx_pkg::rsp_t rsp;

  exec_scoreboard sb = new();

  bit          smooth_flow  = 1'b0;
  bit          growing      = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned cycle_count  = 0;

  stack_machine_executor_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle length: mostly short, a few long
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operand mix weighted toward the extremes
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5, 6:    return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom();
    endcase
  endfunction

  // Response side: check accepted transactions, then choose ready for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (!smooth_flow && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Offer one instruction and wait until it is accepted
  task automatic issue(input smx_pkg::req_op_t op, input logic [31:0] operand);
    smx_pkg::req_t item;
    int unsigned gap;
    item.req_type  = op;
    item.push_data = operand;
    gap = (smooth_flow || $urandom_range(0, 1)) ? 0 : gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    sb.note_instruction(item);
  endtask

  // Withdraw the request and wait for every predicted response
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Well-formed instruction: never underflows, overflows or divides by zero.
  // The stack drifts up to full and back down to exercise long listings.
  task automatic random_step();
    smx_pkg::req_op_t op;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sb.depth_used >= smx_pkg::STACK_DEPTH) growing = 1'b0;
    else if (sb.depth_used <= 2) growing = 1'b1;
    if (roll < 10) begin
      op = smx_pkg::REQ_OUT;
    end else if (sb.depth_used < 2 ||
                 (sb.depth_used < smx_pkg::STACK_DEPTH && roll < (growing ? 90 : 40))) begin
      op = smx_pkg::REQ_PUSH;
    end else begin
      op = smx_pkg::req_op_t'($urandom_range(smx_pkg::REQ_ADD, smx_pkg::REQ_MUL));
      if (op == smx_pkg::REQ_DIV && sb.stack_mem[sb.depth_used-1] == 32'd0) begin
        op = smx_pkg::REQ_SUB;
      end
    end
    issue(op, (op == smx_pkg::REQ_PUSH) ? pick_operand() : $urandom());
  endtask

  initial begin
    int unsigned halt_kind;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty out, single answer, listing, wraps and division rounding
    issue(smx_pkg::REQ_OUT, $urandom());
    issue(smx_pkg::REQ_PUSH, 32'h7FFF_FFFF);
    issue(smx_pkg::REQ_OUT, $urandom());
    issue(smx_pkg::REQ_PUSH, 32'h8000_0000);
    issue(smx_pkg::REQ_OUT, $urandom());
    issue(smx_pkg::REQ_ADD, $urandom());
    issue(smx_pkg::REQ_PUSH, 32'h8000_0000);
    issue(smx_pkg::REQ_PUSH, 32'hFFFF_FFFF);
    issue(smx_pkg::REQ_DIV, $urandom());           // most negative over minus one
    issue(smx_pkg::REQ_PUSH, -32'sd7);
    issue(smx_pkg::REQ_PUSH, 32'd2);
    issue(smx_pkg::REQ_DIV, $urandom());           // negative quotient truncates up
    issue(smx_pkg::REQ_PUSH, 32'd7);
    issue(smx_pkg::REQ_PUSH, -32'sd2);
    issue(smx_pkg::REQ_DIV, $urandom());
    issue(smx_pkg::REQ_SUB, $urandom());
    issue(smx_pkg::REQ_PUSH, 32'h0001_0000);
    issue(smx_pkg::REQ_PUSH, 32'h0001_0000);
    issue(smx_pkg::REQ_MUL, $urandom());           // product wraps to zero
    issue(smx_pkg::REQ_PUSH, 32'h7FFF_FFFF);
    issue(smx_pkg::REQ_ADD, $urandom());
    issue(smx_pkg::REQ_OUT, $urandom());
    wait_drained();

    // Random: a smooth stretch, then a long response hold-off while pushing on
    for (int i = 0; i < 200; i++) begin
      if (i == 40) smooth_flow = 1'b1;
      if (i == 75) smooth_flow = 1'b0;
      if (i == 110) hold_request = 1'b1;
      random_step();
    end
    wait_drained();

    // One halting case per run, picked at random
    halt_kind = $urandom_range(0, 4);
    case (halt_kind)
      0: issue(smx_pkg::REQ_HALT, $urandom());
      1: issue(smx_pkg::REQ_INVALID, $urandom());
      2: begin
        // reduce to one element, then arithmetic underflows
        while (sb.depth_used >= 2) issue(smx_pkg::REQ_ADD, $urandom());
        issue(smx_pkg::req_op_t'($urandom_range(smx_pkg::REQ_ADD, smx_pkg::REQ_MUL)),
              $urandom());
      end
      3: begin
        if (sb.depth_used >= smx_pkg::STACK_DEPTH) issue(smx_pkg::REQ_ADD, $urandom());
        issue(smx_pkg::REQ_PUSH, 32'd0);
        issue(smx_pkg::REQ_DIV, $urandom());
      end
      default: begin
        // fill to the top, list it, then push once more
        while (sb.depth_used < smx_pkg::STACK_DEPTH) begin
          issue(smx_pkg::REQ_PUSH, pick_operand());
        end
        issue(smx_pkg::REQ_OUT, $urandom());
        issue(smx_pkg::REQ_PUSH, $urandom());
      end
    endcase

    // Everything after a halt is ignored
    repeat (6) issue(smx_pkg::req_op_t'($urandom_range(0, 7)), $urandom());

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.pending() != 0) $error("%0d expected responses never arrived", sb.pending());
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
